@@ hdl/kvt_pkg.sv @@
// kvt_pkg: shared constants, codes and types of the key/value table
`default_nettype none

package kvt_pkg;

    localparam int ENTRIES    = 16;
    localparam int KEY_BITS   = 32;
    localparam int VALUE_BITS = 32;

    // port field widths
    localparam int CMD_W   = 2;
    localparam int WORD_W  = 32;
    localparam int STAT_W  = 2;
    localparam int COUNT_W = 5;

    // stored widths: the key and value words are taken modulo 2^KEY_BITS / 2^VALUE_BITS
    localparam int KEY_W = (KEY_BITS < WORD_W) ? KEY_BITS : WORD_W;
    localparam int VAL_W = (VALUE_BITS < WORD_W) ? VALUE_BITS : WORD_W;
    localparam int IDX_W = $clog2(ENTRIES);
    localparam int CNT_W = $clog2(ENTRIES + 1);

    typedef enum logic [CMD_W-1:0] {
        CMD_LOOKUP = 2'd0,
        CMD_SET    = 2'd1,
        CMD_DELETE = 2'd2
    } t_cmd;

    typedef enum logic [STAT_W-1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        WR_NONE,
        WR_NEW,
        WR_VALUE,
        WR_FREE
    } t_wr_op;

    typedef struct packed {
        t_wr_op           op;
        logic [IDX_W-1:0] idx;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
    } t_wr_req;

    typedef struct packed {
        logic             valid;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
    } t_rd_slot;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_APPLY
    } t_state;

endpackage

`default_nettype wire

@@ hdl/kvt_if.sv @@
// kvt_in_if / kvt_out_if: valid/ready channels for commands and results
`default_nettype none

interface kvt_in_if;
    logic                        valid;
    logic                        ready;
    logic [kvt_pkg::CMD_W-1:0]   command;
    logic [kvt_pkg::WORD_W-1:0]  key;
    logic [kvt_pkg::WORD_W-1:0]  write_value;

    modport source (output valid, output command, output key, output write_value,
                    input ready);
    modport sink   (input valid, input command, input key, input write_value,
                    output ready);
endinterface

interface kvt_out_if;
    logic                         valid;
    logic                         ready;
    logic [kvt_pkg::STAT_W-1:0]   status;
    logic                         hit;
    logic [kvt_pkg::WORD_W-1:0]   read_value;
    logic                         overwrote;
    logic [kvt_pkg::COUNT_W-1:0]  entry_count;

    modport source (output valid, output status, output hit, output read_value,
                    output overwrote, output entry_count, input ready);
    modport sink   (input valid, input status, input hit, input read_value,
                    input overwrote, input entry_count, output ready);
endinterface

`default_nettype wire

@@ hdl/kvt_store.sv @@
// kvt_store: slot key/value memory with registered read and valid flags
`default_nettype none

module kvt_store (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic [kvt_pkg::IDX_W-1:0] i_rd_idx,
    input  wire kvt_pkg::t_wr_req        i_wr,
    output kvt_pkg::t_rd_slot            o_rd
);
    import kvt_pkg::*;

    logic [KEY_W-1:0]   r_key_mem [ENTRIES];
    logic [VAL_W-1:0]   r_val_mem [ENTRIES];
    logic [ENTRIES-1:0] r_vld;
    t_rd_slot           r_rd;

    // valid flags, cleared at reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            unique case (i_wr.op)
                WR_NEW:   r_vld[i_wr.idx] <= 1'b1;
                WR_FREE:  r_vld[i_wr.idx] <= 1'b0;
                WR_NONE,
                WR_VALUE: ;
                default:  ;
            endcase
        end
    end

    // key/value memory, one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (i_wr.op == WR_NEW) begin
            r_key_mem[i_wr.idx] <= i_wr.key;
        end
        if (i_wr.op == WR_NEW || i_wr.op == WR_VALUE) begin
            r_val_mem[i_wr.idx] <= i_wr.value;
        end
        r_rd.key   <= r_key_mem[i_rd_idx];
        r_rd.value <= r_val_mem[i_rd_idx];
        r_rd.valid <= r_vld[i_rd_idx];
    end

    assign o_rd = r_rd;

endmodule

`default_nettype wire

@@ hdl/key_value_table_top.sv @@
// key_value_table_top: linear-search key/value table with a slot scan sequencer
//
//  channel  dir  transaction                            payload
//  i_in     in   one command: lookup, set or delete     command, key, write_value
//  o_out    out  one result per command                 status, hit, read_value,
//                                                       overwrote, entry_count
//
//  the result is loaded after a scan of every slot in order: one slot memory read
//  per cycle through the single key compare unit, then a drain state for the
//  registered read, then an apply state that updates the slot and loads the result
//  i_in.ready is high only while the sequencer is idle, so a new command is not
//  accepted until the previous one has left its apply state
//  a result waits in the output register; the next command may be accepted meanwhile
//  and stalls in its apply state until the output register is free
//  reset clears the valid flags and the entry count at once; no clearing pass
`default_nettype none

module key_value_table_top (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    kvt_in_if.sink    i_in,
    kvt_out_if.source o_out
);
    import kvt_pkg::*;

    // sequencer state
    t_state             r_state, n_state;
    logic [IDX_W-1:0]   r_idx, n_idx;
    logic               r_pv;          // read data of r_rd_idx is at the compare stage
    logic [IDX_W-1:0]   r_rd_idx;

    // captured command
    logic [CMD_W-1:0]   r_cmd;
    logic [KEY_W-1:0]   r_key;
    logic [VAL_W-1:0]   r_val;

    // scan results
    logic               r_found;
    logic [IDX_W-1:0]   r_found_idx;
    logic [VAL_W-1:0]   r_found_val;
    logic               r_free_ok;
    logic [IDX_W-1:0]   r_free_idx;

    logic [CNT_W-1:0]   r_count, n_count;

    // output register
    logic               r_out_vld;
    logic [STAT_W-1:0]  r_out_status;
    logic               r_out_hit;
    logic [WORD_W-1:0]  r_out_rval;
    logic               r_out_over;
    logic [COUNT_W-1:0] r_out_count;

    t_wr_req            wr;
    t_rd_slot           rd;
    logic               accept;
    logic               out_take;
    logic               load_out;
    logic               match;
    t_status            res_status;
    logic               res_hit;
    logic [VAL_W-1:0]   res_rval;
    logic               res_over;

    kvt_store u_store (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_rd_idx (r_idx),
        .i_wr     (wr),
        .o_rd     (rd)
    );

    assign accept   = i_in.valid && i_in.ready;
    assign out_take = r_out_vld && o_out.ready;

    // shared compare unit: one slot per cycle
    assign match = r_pv && rd.valid && (rd.key == r_key);

    // sequencer: next state, store write and result
    always_comb begin
        n_state    = r_state;
        n_idx      = r_idx;
        n_count    = r_count;
        load_out   = 1'b0;
        wr.op      = WR_NONE;
        wr.idx     = r_found_idx;
        wr.key     = r_key;
        wr.value   = r_val;
        res_status = ST_OK;
        res_hit    = 1'b0;
        res_rval   = '0;
        res_over   = 1'b0;
        i_in.ready = 1'b0;

        // decision from the finished scan
        unique case (r_cmd)
            CMD_LOOKUP: begin
                res_hit = r_found;
                if (r_found) begin
                    res_rval = r_found_val;
                end else begin
                    res_status = ST_NOT_FOUND;
                end
            end
            CMD_SET: begin
                if (r_found) begin
                    res_hit  = 1'b1;
                    res_over = 1'b1;
                end else if (!r_free_ok) begin
                    res_status = ST_FULL;
                end
            end
            CMD_DELETE: begin
                res_hit = r_found;
                if (!r_found) begin
                    res_status = ST_NOT_FOUND;
                end
            end
            default: ;  // unused code: no change, status ok
        endcase

        unique case (r_state)
            S_IDLE: begin
                i_in.ready = 1'b1;
                if (accept) begin
                    n_state = S_SCAN;
                    n_idx   = '0;
                end
            end
            S_SCAN: begin
                if (r_idx == IDX_W'(ENTRIES - 1)) begin
                    n_state = S_DRAIN;
                end else begin
                    n_idx = r_idx + IDX_W'(1);
                end
            end
            S_DRAIN: begin
                n_state = S_APPLY;
            end
            S_APPLY: begin
                // commit only once the output register can take the result
                if (!r_out_vld || o_out.ready) begin
                    load_out = 1'b1;
                    n_state  = S_IDLE;
                    if (r_cmd == CMD_SET && r_found) begin
                        wr.op = WR_VALUE;
                    end else if (r_cmd == CMD_SET && r_free_ok) begin
                        wr.op   = WR_NEW;
                        wr.idx  = r_free_idx;
                        n_count = r_count + CNT_W'(1);
                    end else if (r_cmd == CMD_DELETE && r_found) begin
                        wr.op = WR_FREE;
                        if (r_count != '0) begin
                            n_count = r_count - CNT_W'(1);
                        end
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_idx     <= '0;
            r_pv      <= 1'b0;
            r_count   <= '0;
            r_out_vld <= 1'b0;
            r_found   <= 1'b0;
            r_free_ok <= 1'b0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_pv    <= (r_state == S_SCAN);
            r_count <= n_count;
            if (load_out) begin
                r_out_vld <= 1'b1;
            end else if (out_take) begin
                r_out_vld <= 1'b0;
            end
            if (accept) begin
                r_found   <= 1'b0;
                r_free_ok <= 1'b0;
            end else begin
                if (match && !r_found) begin
                    r_found <= 1'b1;
                end
                // lowest free slot is the first invalid one seen
                if (r_pv && !rd.valid && !r_free_ok) begin
                    r_free_ok <= 1'b1;
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_rd_idx <= r_idx;
        if (accept) begin
            r_cmd <= i_in.command;
            r_key <= KEY_W'(i_in.key);
            r_val <= VAL_W'(i_in.write_value);
        end
        if (match && !r_found) begin
            r_found_idx <= r_rd_idx;
            r_found_val <= rd.value;
        end
        if (r_pv && !rd.valid && !r_free_ok) begin
            r_free_idx <= r_rd_idx;
        end
        if (load_out) begin
            r_out_status <= res_status;
            r_out_hit    <= res_hit;
            r_out_rval   <= WORD_W'(res_rval);
            r_out_over   <= res_over;
            r_out_count  <= COUNT_W'(n_count);
        end
    end

    assign o_out.valid       = r_out_vld;
    assign o_out.status      = r_out_status;
    assign o_out.hit         = r_out_hit;
    assign o_out.read_value  = r_out_rval;
    assign o_out.overwrote   = r_out_over;
    assign o_out.entry_count = r_out_count;

`ifndef SYNTHESIS
    // the entry count never passes the table depth
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(ENTRIES))
        else $error("entry count above table depth");

    // a full report only comes with a full table
    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_out_status == ST_FULL) |-> (r_out_count == COUNT_W'(ENTRIES)))
        else $error("table full reported with free slots");

    // an accepted command starts its scan at slot zero
    a_scan_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == S_SCAN && r_idx == '0))
        else $error("scan did not start at slot zero");

    // an overwrite is always a hit
    a_over_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_out_over) |-> r_out_hit)
        else $error("overwrite without hit");
`endif

endmodule

`default_nettype wire
